@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each macro takes a label, the clock, the active-low reset, the property
// (an expression that must never hold, for RY_NEVER) and the message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RY_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RY_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RY_ASSERT(label, clk, rst_n, prop, msg)
`define RY_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

@@ src/ryuv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ryuv_pkg;

    // Frame limits and line store geometry
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int DIM_W       = 13;
    localparam int POS_W       = 12;
    localparam int IDX_W       = 24;
    localparam int PAIR_W      = 27;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // Register map
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Output plane codes
    typedef enum logic [1:0] {
        PLANE_Y  = 2'd0,
        PLANE_CB = 2'd1,
        PLANE_CR = 2'd2
    } t_plane;

    // Everything one pixel produces, handed to the output sequencer
    typedef struct packed {
        logic [7:0]       luma;
        logic [IDX_W-1:0] luma_index;
        logic [7:0]       cb;
        logic [7:0]       cr;
        logic [IDX_W-1:0] chroma_index;
        logic             has_chroma;
    } t_result_set;

    // Limit a frame dimension to 2..hi
    function automatic logic [DIM_W-1:0] f_clamp_dim(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        if (v < 13'd2) begin
            res = 13'd2;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Y = ((128 + 66R + 129G + 25B) >> 8) + 16
    function automatic logic [7:0] f_luma(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        logic [15:0] s;
        s = 16'd128 + 16'd66 * {8'd0, r} + 16'd129 * {8'd0, g} + 16'd25 * {8'd0, b};
        return s[15:8] + 8'd16;
    endfunction

    // Cb with a 32768 bias plus 128 for rounding so the sum never goes negative
    function automatic logic [7:0] f_cb(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        logic [15:0] s;
        s = 16'd32896 + 16'd112 * {8'd0, b} - 16'd38 * {8'd0, r} - 16'd74 * {8'd0, g};
        return s[15:8];
    endfunction

    // Cr, same bias
    function automatic logic [7:0] f_cr(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        logic [15:0] s;
        s = 16'd32896 + 16'd112 * {8'd0, r} - 16'd94 * {8'd0, g} - 16'd18 * {8'd0, b};
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

@@ src/ryuv_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Output sequencer: plays out Y, then Cb and Cr when the pixel closes a block
module ryuv_emit import ryuv_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_result_set i_set,
    output logic             o_free,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // sample[7:0], sample_index[31:8]
    output logic [1:0]       m_axis_tuser,   // plane[1:0]
    output logic             m_axis_tlast
);

    logic        r_valid, n_valid;
    t_plane      r_sel, n_sel;
    t_result_set r_set;
    logic        fire;
    logic        is_last;
    logic        take;

    assign is_last = !r_set.has_chroma || (r_sel == PLANE_CR);
    assign fire    = r_valid && m_axis_tready;
    assign o_free  = !r_valid || (fire && is_last);
    assign take    = i_load && o_free;

    // Next state
    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        priority if (take) begin
            n_valid = 1'b1;
            n_sel   = PLANE_Y;
        end else if (fire) begin
            if (is_last) begin
                n_valid = 1'b0;
            end else begin
                unique case (r_sel)
                    PLANE_Y:  n_sel = PLANE_CB;
                    PLANE_CB: n_sel = PLANE_CR;
                    default:  n_sel = PLANE_Y;
                endcase
            end
        end else begin
            // hold
            n_valid = r_valid;
            n_sel   = r_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= PLANE_Y;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    // Held result set
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_set <= i_set;
        end
    end

    // Outputs
    always_comb begin
        m_axis_tvalid = r_valid;
        m_axis_tuser  = r_sel;
        m_axis_tlast  = is_last;
        unique case (r_sel)
            PLANE_Y:  m_axis_tdata = {r_set.luma_index, r_set.luma};
            PLANE_CB: m_axis_tdata = {r_set.chroma_index, r_set.cb};
            PLANE_CR: m_axis_tdata = {r_set.chroma_index, r_set.cr};
            default:  m_axis_tdata = {r_set.luma_index, r_set.luma};
        endcase
    end

    `RY_ASSERT(a_chroma_sel_needs_set, i_clk, i_rst_n, r_valid && (r_sel != PLANE_Y) |-> r_set.has_chroma, "chroma plane selected for a luma-only pixel")
    `RY_ASSERT(a_take_starts_luma, i_clk, i_rst_n, take |=> r_valid && (r_sel == PLANE_Y), "new result set does not start with luma")
    `RY_ASSERT(a_mid_set_advances, i_clk, i_rst_n, fire && !is_last |=> r_valid && (r_sel != PLANE_Y), "result set cut short")

endmodule

`default_nettype wire

@@ src/rgb_to_yuv420_block_averaged.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// RGB to YCbCr 4:2:0 converter (BT.601 studio range, 2x2 chroma averaging).
// Pixels stream in raster order; s_axis_tuser marks the first pixel of a frame.
// Each pixel yields a Y sample; the bottom-right pixel of each complete 2x2
// block yields Y, Cb, Cr in that order, with tlast on the final sample of each
// pixel. tuser on the output gives the plane and tdata carries the sample and
// its raster index within that plane. A pixel is taken every cycle while the
// pipeline can advance; a block-closing pixel holds the output until its Y, Cb
// and Cr have left, results leaving one per cycle while the receiver is ready.
// The first result is offered after the stage 1, stage 2 and output registers.
// The top-row pair sums of each block sit in a 2048-entry line memory with a
// registered read; it needs no clearing after reset. The user must write
// frame_width and frame_height over APB only while the block is idle; the block
// itself does not enforce this. Values below 2 act as 2, values above 4096 as 4096.
module rgb_to_yuv420_block_averaged import ryuv_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Pixel input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  wire logic        s_axis_tuser,   // frame_start[0]
    // Sample output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // sample[7:0], sample_index[31:8]
    output logic [1:0]       m_axis_tuser,   // plane[1:0]
    output logic             m_axis_tlast,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FRAME_WIDTH) begin
                r_frame_width <= pwdata[DIM_W-1:0];
            end else begin
                r_frame_height <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? {19'd0, r_frame_height}
                                                  : {19'd0, r_frame_width};

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    assign w_eff = f_clamp_dim(r_frame_width, DIM_W'(MAX_WIDTH));
    assign h_eff = f_clamp_dim(r_frame_height, DIM_W'(MAX_HEIGHT));

    // Pipeline handshake
    logic emit_free;
    logic r_s1_valid, r_s2_valid;
    logic s1_adv, s2_adv;
    logic acc;

    assign s2_adv        = !r_s2_valid || emit_free;
    assign s1_adv        = !r_s1_valid || s2_adv;
    assign s_axis_tready = s1_adv;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // Pixel position
    logic [7:0]       in_r, in_g, in_b;
    logic [POS_W-1:0] r_col, r_row, n_col, n_row;
    logic [POS_W-1:0] base_col, base_row, pre_row;
    logic [POS_W-1:0] cur_col, cur_row;
    logic [DIM_W-1:0] col_inc, row_inc;

    assign in_r = s_axis_tdata[7:0];
    assign in_g = s_axis_tdata[15:8];
    assign in_b = s_axis_tdata[23:16];

    always_comb begin
        base_col = s_axis_tuser ? '0 : r_col;
        base_row = s_axis_tuser ? '0 : r_row;
        // wrap a position left stale by a smaller frame
        if ({1'b0, base_col} >= w_eff) begin
            cur_col = '0;
            pre_row = base_row + 12'd1;
        end else begin
            cur_col = base_col;
            pre_row = base_row;
        end
        cur_row = ({1'b0, pre_row} >= h_eff) ? '0 : pre_row;
        // advance
        col_inc = {1'b0, cur_col} + 13'd1;
        row_inc = {1'b0, cur_row} + 13'd1;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
        end else begin
            n_col = col_inc[POS_W-1:0];
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Left pixel of the current column pair
    logic [23:0] r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (acc && !cur_col[0]) begin
            r_left <= {in_b, in_g, in_r};
        end
    end

    // Horizontal pair sums
    logic [8:0]        sum_r, sum_g, sum_b;
    logic [PAIR_W-1:0] pair_sum;
    logic [LINE_AW-1:0] slot;

    assign sum_r    = {1'b0, in_r} + {1'b0, r_left[7:0]};
    assign sum_g    = {1'b0, in_g} + {1'b0, r_left[15:8]};
    assign sum_b    = {1'b0, in_b} + {1'b0, r_left[23:16]};
    assign pair_sum = {sum_b, sum_g, sum_r};
    assign slot     = cur_col[LINE_AW:1];

    // Line memory of top-row pair sums. Writes come on even rows at the odd
    // column; a read happens at every transfer, but only odd-row reads are used,
    // so a read that meets a write to the same entry is never used.
    logic [PAIR_W-1:0] r_line [LINE_DEPTH];
    logic [PAIR_W-1:0] r_mem_q;

    always_ff @(posedge i_clk) begin
        if (acc && cur_col[0] && !cur_row[0]) begin
            r_line[slot] <= pair_sum;
        end
        if (acc) begin
            r_mem_q <= r_line[slot];
        end
    end

    // Stage 1: pixel in flight while the top pair is read
    logic [7:0]        r_s1_r, r_s1_g, r_s1_b;
    logic [POS_W-1:0]  r_s1_col, r_s1_row;
    logic [PAIR_W-1:0] r_s1_pair;
    logic              r_s1_chroma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_r      <= in_r;
            r_s1_g      <= in_g;
            r_s1_b      <= in_b;
            r_s1_col    <= cur_col;
            r_s1_row    <= cur_row;
            r_s1_pair   <= pair_sum;
            r_s1_chroma <= cur_col[0] && cur_row[0];
        end
    end

    // Block averages, luma, index products
    logic [9:0]  blk_r, blk_g, blk_b;
    logic [24:0] luma_prod;
    logic [22:0] chroma_prod;

    assign blk_r = {1'b0, r_s1_pair[8:0]}   + {1'b0, r_mem_q[8:0]};
    assign blk_g = {1'b0, r_s1_pair[17:9]}  + {1'b0, r_mem_q[17:9]};
    assign blk_b = {1'b0, r_s1_pair[26:18]} + {1'b0, r_mem_q[26:18]};
    assign luma_prod   = {13'd0, r_s1_row} * {12'd0, w_eff};
    assign chroma_prod = {12'd0, r_s1_row[POS_W-1:1]} * {11'd0, w_eff[DIM_W-1:1]};

    // Stage 2
    logic [7:0]       r_s2_luma;
    logic [7:0]       r_s2_ar, r_s2_ag, r_s2_ab;
    logic [IDX_W-1:0] r_s2_lprod, r_s2_cprod;
    logic [POS_W-1:0] r_s2_col;
    logic             r_s2_chroma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_valid) begin
            r_s2_luma   <= f_luma(r_s1_r, r_s1_g, r_s1_b);
            r_s2_ar     <= blk_r[9:2];
            r_s2_ag     <= blk_g[9:2];
            r_s2_ab     <= blk_b[9:2];
            r_s2_lprod  <= luma_prod[IDX_W-1:0];
            r_s2_cprod  <= {1'b0, chroma_prod};
            r_s2_col    <= r_s1_col;
            r_s2_chroma <= r_s1_chroma;
        end
    end

    // Final indices and chroma
    t_result_set s2_set;

    always_comb begin
        s2_set.luma         = r_s2_luma;
        s2_set.luma_index   = r_s2_lprod + {12'd0, r_s2_col};
        s2_set.cb           = f_cb(r_s2_ar, r_s2_ag, r_s2_ab);
        s2_set.cr           = f_cr(r_s2_ar, r_s2_ag, r_s2_ab);
        s2_set.chroma_index = r_s2_cprod + {13'd0, r_s2_col[POS_W-1:1]};
        s2_set.has_chroma   = r_s2_chroma;
    end

    ryuv_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (r_s2_valid),
        .i_set         (s2_set),
        .o_free        (emit_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `RY_NEVER(a_no_take_when_full, i_clk, i_rst_n, s_axis_tready && r_s1_valid && r_s2_valid && !emit_free, "pixel taken while pipeline is full")
    `RY_ASSERT(a_s2_holds_on_stall, i_clk, i_rst_n, r_s2_valid && !emit_free |=> r_s2_valid && $stable(r_s2_lprod), "stage 2 lost or changed while stalled")
    `RY_ASSERT(a_s1_holds_on_stall, i_clk, i_rst_n, r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_col), "stage 1 lost or changed while stalled")

endmodule

`default_nettype wire

@@ verif/tb_rgb_to_yuv420_block_averaged.sv @@
`timescale 1ns / 1ps

module tb_rgb_to_yuv420_block_averaged;
    import ryuv_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int FRAME_CAP      = 48;

    localparam logic [2:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

    // One output sample as the block should produce it
    typedef struct packed {
        t_plane           plane;
        logic [7:0]       sample;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_sample;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // red[7:0], green[15:8], blue[23:16]
    logic        s_axis_tuser  = 1'b0; // frame_start[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // sample[7:0], sample_index[31:8]
    logic [1:0]  m_axis_tuser;         // plane[1:0]
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Converter shadow state
    logic [DIM_W-1:0] cfg_width  = WIDTH_RESET;
    logic [DIM_W-1:0] cfg_height = HEIGHT_RESET;
    int cur_col = 0;
    int cur_row = 0;
    int left_r = 0, left_g = 0, left_b = 0;
    int pair_r [LINE_DEPTH];
    int pair_g [LINE_DEPTH];
    int pair_b [LINE_DEPTH];

    t_sample expected_samples [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_hold_request = 1'b0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int n_pixels = 0;
    int n_samples = 0;
    int n_chroma = 0;
    int n_geometries = 0;

    rgb_to_yuv420_block_averaged dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int dim_limit(input int v, input int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    // Convert one pixel: luma always, chroma on the closing pixel of a 2x2 block
    function automatic void convert_pixel(input logic [7:0] r, g, b, input logic fs);
        int w, h, col, row, slot, luma, sr, sg, sb, ar, ag, ab, cb, cr;
        logic [IDX_W-1:0] luma_idx, chroma_idx;
        bit closes_block;
        w = dim_limit(cfg_width, MAX_WIDTH);
        h = dim_limit(cfg_height, MAX_HEIGHT);
        if (fs) begin
            cur_col = 0;
            cur_row = 0;
        end
        // position left beyond the frame by a register change
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = (cur_row + 1) & 'hFFF;
        end
        if (cur_row >= h) cur_row = 0;
        col = cur_col;
        row = cur_row;
        slot = (col >> 1) & (LINE_DEPTH - 1);
        luma = ((128 + 66 * r + 129 * g + 25 * b) >> 8) + 16;
        luma_idx = IDX_W'(row * w + col);
        chroma_idx = '0;
        cb = 0;
        cr = 0;
        closes_block = 1'b0;
        if ((col & 1) == 0) begin
            left_r = r;
            left_g = g;
            left_b = b;
        end else begin
            sr = r + left_r;
            sg = g + left_g;
            sb = b + left_b;
            if ((row & 1) == 0) begin
                pair_r[slot] = sr;
                pair_g[slot] = sg;
                pair_b[slot] = sb;
            end else begin
                ar = (sr + pair_r[slot]) >> 2;
                ag = (sg + pair_g[slot]) >> 2;
                ab = (sb + pair_b[slot]) >> 2;
                cb = ((128 - 38 * ar - 74 * ag + 112 * ab) >>> 8) + 128;
                cr = ((128 + 112 * ar - 94 * ag - 18 * ab) >>> 8) + 128;
                chroma_idx = IDX_W'((row >> 1) * (w >> 1) + (col >> 1));
                closes_block = 1'b1;
            end
        end
        expected_samples.push_back('{PLANE_Y, 8'(luma), luma_idx, !closes_block});
        if (closes_block) begin
            expected_samples.push_back('{PLANE_CB, 8'(cb), chroma_idx, 1'b0});
            expected_samples.push_back('{PLANE_CR, 8'(cr), chroma_idx, 1'b1});
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        cur_col = col & 'hFFF;
        cur_row = row & 'hFFF;
    endfunction

    // Mostly full-range values, with the extremes weighted up
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Pixel transfer; tvalid stays high afterwards until the next call or a drain
    task automatic send_pixel(input logic [7:0] r, g, b, input logic fs);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        s_axis_tuser  <= fs;
        do @(posedge i_clk); while (!s_axis_tready);
        convert_pixel(r, g, b, fs);
        n_pixels++;
    endtask

    task automatic send_random_pixel(input logic fs);
        send_pixel(pick_channel(), pick_channel(), pick_channel(), fs);
    endtask

    // Stop offering pixels and wait for every pending sample
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic [2:0] addr, input logic [DIM_W-1:0] want);
        logic [31:0] rd;
        apb_access(1'b0, addr, '0, rd);
        if (rd !== 32'(want)) begin
            $error("%s: expected %0d, got %0d",
                   (addr == ADDR_FRAME_WIDTH) ? "frame_width" : "frame_height", want, rd);
            fail_count++;
        end
    endtask

    task automatic write_register(input logic [2:0] addr, input int value);
        logic [31:0] rd;
        apb_access(1'b1, addr, 32'(value), rd);
        if (addr == ADDR_FRAME_WIDTH) begin
            cfg_width = DIM_W'(value);
        end else begin
            cfg_height = DIM_W'(value);
        end
        check_register(addr, DIM_W'(value));
    endtask

    task automatic set_geometry(input int w, input int h);
        wait_for_drain();
        write_register(ADDR_FRAME_WIDTH, w);
        write_register(ADDR_FRAME_HEIGHT, h);
        n_geometries++;
    endtask

    // Receiver side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_request) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_request = 1'b0;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each sample transfer with the oldest pending one
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_samples++;
            if (m_axis_tuser != PLANE_Y) n_chroma++;
            if (expected_samples.size() == 0) begin
                $error("unexpected sample: plane %0d, sample %0d, index %0d",
                       m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[31:8]);
                fail_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_axis_tuser !== want.plane) begin
                    $error("plane: expected %0d, got %0d", want.plane, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[7:0] !== want.sample) begin
                    $error("sample: expected %0d, got %0d", want.sample, m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tdata[31:8] !== want.index) begin
                    $error("sample_index: expected %0d, got %0d",
                           want.index, m_axis_tdata[31:8]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Reset geometry, then a few pixels from the reset position
    task automatic test_reset_state();
        check_register(ADDR_FRAME_WIDTH, WIDTH_RESET);
        check_register(ADDR_FRAME_HEIGHT, HEIGHT_RESET);
        repeat (6) send_random_pixel(1'b0);
    endtask

    // Smallest frame, values below range clamp to 2x2; extreme colors
    task automatic test_corner_pixels();
        set_geometry(0, 1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        // pure blue block, then pure red block: chroma extremes
        repeat (4) send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        repeat (4) send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        repeat (2) send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        repeat (2) send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    endtask

    // Odd last column and row give luma only; frame start mid-frame
    task automatic test_odd_edges();
        set_geometry(3, 3);
        send_random_pixel(1'b1);
        repeat (9) send_random_pixel(1'b0);
        send_random_pixel(1'b1);
    endtask

    // Register changes that leave the position beyond the frame
    task automatic test_position_wrap();
        set_geometry(6, 8);
        send_random_pixel(1'b1);
        repeat (15) send_random_pixel(1'b0);
        // now at row 2 column 4; column wraps into odd row 3
        wait_for_drain();
        write_register(ADDR_FRAME_WIDTH, 4);
        repeat (8) send_random_pixel(1'b0);
        // now at row 5; row wraps to 0
        wait_for_drain();
        write_register(ADDR_FRAME_HEIGHT, 2);
        repeat (8) send_random_pixel(1'b0);
    endtask

    // Long output stall with the sender still pushing, then a full drain
    task automatic test_output_stall();
        int k;
        set_geometry(4, 4);
        rx_hold_request = 1'b1;
        for (k = 0; k < 40; k++) send_random_pixel(k == 0);
        wait_for_drain();
        repeat (16) send_random_pixel(1'b0);
    endtask

    // Oversized width clamps to the maximum, height at the maximum; start of a full-width row
    task automatic test_widest_line();
        int k;
        set_geometry(8191, 4096);
        for (k = 0; k < 24; k++) send_random_pixel(k == 0);
    endtask

    // Random frames, mostly small, with stray frame starts as noise
    task automatic test_random_frames(input int budget);
        int sent, w, h, area, n, k;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(19))
                0: w = $urandom_range(1);
                1: w = $urandom_range(17, 40);
                2: w = $urandom_range(4097, 8191);
                default: w = $urandom_range(2, 10);
            endcase
            case ($urandom_range(19))
                0: h = $urandom_range(1);
                1: h = $urandom_range(4097, 8191);
                default: h = $urandom_range(2, 6);
            endcase
            set_geometry(w, h);
            area = dim_limit(w, MAX_WIDTH) * dim_limit(h, MAX_HEIGHT);
            if (area > FRAME_CAP) area = FRAME_CAP;
            n = $urandom_range(area / 2 + 1, area * 2);
            if (n > FRAME_CAP) n = FRAME_CAP;
            for (k = 0; k < n; k++) send_random_pixel(k == 0 || $urandom_range(29) == 0);
            sent += n;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 28;
        rx_idle_pct = 70;
        test_reset_state();
        test_corner_pixels();
        test_odd_edges();
        test_position_wrap();
        test_random_frames(45);

        tx_idle_pct = 70;
        rx_idle_pct = 28;
        test_output_stall();
        test_random_frames(45);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_widest_line();
        test_random_frames(35);

        wait_for_drain();
        $display("covered %0d pixels over %0d frame geometries", n_pixels, n_geometries);
        $display("checked %0d samples, %0d of them chroma", n_samples, n_chroma);
        if (fail_count == 0 && expected_samples.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/ryuv_pkg.sv
src/ryuv_emit.sv
src/rgb_to_yuv420_block_averaged.sv
verif/tb_rgb_to_yuv420_block_averaged.sv
